// ===== src/ffe_pkg.sv =====
// ----------------------------------------------------------------------------
// ffe_pkg - shared types and constants of the first-fit extent allocator
// Item layouts, operation and status codes, extent table entry format.
// ----------------------------------------------------------------------------
package ffe_pkg;

    // default sizing
    localparam int MAX_EXTENTS_DEF  = 64;
    localparam int HEADER_BYTES_DEF = 4;

    // field widths
    localparam int OFS_W  = 24;   // offsets and sizes carried in items
    localparam int LEN_W  = 25;   // extent lengths, starts, totals
    localparam int NEED_W = 26;   // span ends and rounded request plus header

    localparam logic [LEN_W-1:0] POOL_MAX   = 25'd16777216;
    localparam logic [LEN_W-1:0] POOL_RESET = 25'd65536;
    localparam logic [LEN_W-1:0] TOTAL_MAX  = 25'h1FFFFFF;

    // operations
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [OFS_W-1:0] request_size;
        logic [OFS_W-1:0] free_offset;
        logic [OFS_W-1:0] freed_word;
    } ffe_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFS_W-1:0] data_offset;
        logic [OFS_W-1:0] header_word;
        logic [LEN_W-1:0] bytes_in_use;
        logic [LEN_W-1:0] peak_bytes;
    } ffe_out_t;

    // one free extent as held in the table memory
    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] length;
    } ffe_ext_t;

    localparam int EXT_W = $bits(ffe_ext_t);

endpackage

// ===== src/ffe_ram.sv =====
// ----------------------------------------------------------------------------
// ffe_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/first_fit_extent_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_unit - first-fit pool allocator with coalescing
// Address-sorted free extent table in one RAM; allocate carves the first
// fitting extent, free merges with neighbors or inserts a new extent.
// ----------------------------------------------------------------------------
// Steps: allocate scans the table from the first entry to the first fit and
// closes the gap when an extent is used up; free scans to the insertion point,
// then merges, extends, removes or inserts an entry; pool reset writes one extent.
// One item at a time: a new item is taken only in idle, and each table walk is
// bound by the single read and write port of the extent table RAM.
// Reset: one cycle after aresetn rises the table holds one 65536-byte extent.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_unit
    import ffe_pkg::*;
#(
    parameter int MAX_EXTENTS        = MAX_EXTENTS_DEF,
    parameter int ALLOC_HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // request items
    input  logic             s_valid,
    output logic             s_ready,
    input  ffe_in_t          s_data,
    // result items
    output logic             m_valid,
    input  logic             m_ready,
    output ffe_out_t         m_data,
    // pool size register
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [LEN_W-1:0] HDR = LEN_W'(ALLOC_HEADER_BYTES);

    typedef enum logic [6:0] {
        S_INIT     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_DECIDE   = 7'b0001000,
        S_SHIFT_DN = 7'b0010000,
        S_SHIFT_UP = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  pool_size_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [LEN_W-1:0]  in_use_reg, in_use_next;
    logic [LEN_W-1:0]  peak_reg, peak_next;

    // per-item working registers
    logic [1:0]        op_reg, op_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [OFS_W-1:0]  word_reg, word_next;
    logic [OFS_W-1:0]  data_reg, data_next;
    logic [1:0]        status_reg, status_next;
    logic [LEN_W-1:0]  fs_reg, fs_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;
    logic [NEED_W-1:0] fe_reg, fe_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     chk_reg, chk_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [CW-1:0]     mv_reg, mv_next;
    logic [CW-1:0]     ins_reg, ins_next;
    ffe_ext_t          prev_reg, prev_next;
    logic              prev_vld_reg, prev_vld_next;
    ffe_ext_t          cur_reg, cur_next;
    logic              cur_vld_reg, cur_vld_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    ffe_out_t          m_data_reg, m_data_next;

    // table memory ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    ffe_ext_t          mem_wdata, mem_rdata;

    // combinational helpers
    logic [LEN_W-1:0]  eff_pool;
    logic [LEN_W-1:0]  rounded;
    logic [CW-1:0]     ins_m1;
    logic              rd_more;
    logic [LEN_W+1:0]  alloc_sum;
    logic [LEN_W-1:0]  alloc_total;
    logic [NEED_W-1:0] prev_end;
    logic              bad_span, left, right;

    ffe_ram #(
        .WIDTH(EXT_W),
        .DEPTH(MAX_EXTENTS)
    ) u_table (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // helper arithmetic
    assign eff_pool = (pool_size_reg > POOL_MAX) ? POOL_MAX : pool_size_reg;
    assign rounded  = (LEN_W'(s_data.request_size) + LEN_W'(3)) & ~LEN_W'(3);
    assign ins_m1   = ins_reg - CNT_ONE;
    assign rd_more  = (idx_reg < count_reg);
    assign alloc_sum   = (LEN_W+2)'(in_use_reg) + (LEN_W+2)'(need_reg);
    assign alloc_total = (alloc_sum > (LEN_W+2)'(TOTAL_MAX)) ? TOTAL_MAX
                                                               : alloc_sum[LEN_W-1:0];
    assign prev_end = NEED_W'(prev_reg.start) + NEED_W'(prev_reg.length);
    assign bad_span = (fe_reg > NEED_W'(pool_size_reg))
                   || (prev_vld_reg && (prev_end > NEED_W'(fs_reg)))
                   || (cur_vld_reg && (NEED_W'(cur_reg.start) < fe_reg));
    assign left  = prev_vld_reg && (prev_end == NEED_W'(fs_reg));
    assign right = cur_vld_reg && (NEED_W'(cur_reg.start) == fe_reg);

    // control and datapath
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        in_use_next   = in_use_reg;
        peak_next     = peak_reg;
        op_next       = op_reg;
        need_next     = need_reg;
        word_next     = word_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        fs_next       = fs_reg;
        flen_next     = flen_reg;
        fe_next       = fe_reg;
        idx_next      = idx_reg;
        chk_next      = chk_reg;
        chk_vld_next  = chk_vld_reg;
        mv_next       = mv_reg;
        ins_next      = ins_reg;
        prev_next     = prev_reg;
        prev_vld_next = prev_vld_reg;
        cur_next      = cur_reg;
        cur_vld_next  = cur_vld_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = idx_reg[AW-1:0];

        case (state_reg)
            // seed the table with one extent after reset
            S_INIT: begin
                mem_we     = 1'b1;
                mem_wdata  = '{start: '0, length: POOL_RESET};
                count_next = CNT_ONE;
                state_next = S_IDLE;
            end

            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_data.operation;
                    status_next   = ST_OK;
                    data_next     = '0;
                    word_next     = '0;
                    idx_next      = '0;
                    chk_vld_next  = 1'b0;
                    prev_vld_next = 1'b0;
                    need_next     = NEED_W'(rounded) + NEED_W'(HDR);
                    word_next     = '0;
                    fs_next       = LEN_W'(s_data.free_offset) - HDR;
                    flen_next     = LEN_W'(s_data.freed_word) + HDR;
                    fe_next       = NEED_W'(LEN_W'(s_data.free_offset) - HDR)
                                  + NEED_W'(LEN_W'(s_data.freed_word) + HDR);
                    case (s_data.operation)
                        OP_ALLOC: begin
                            state_next = S_SCAN;
                        end
                        OP_FREE: begin
                            if (LEN_W'(s_data.free_offset) < HDR) begin
                                status_next = ST_NO_FIT;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_RESET: begin
                            mem_we      = 1'b1;
                            mem_wdata   = '{start: '0, length: eff_pool};
                            count_next  = (eff_pool != '0) ? CNT_ONE : '0;
                            in_use_next = '0;
                            peak_next   = '0;
                            state_next  = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // pipelined walk: issue read of idx, check entry chk
            S_SCAN: begin
                chk_vld_next = rd_more;
                chk_next     = idx_reg;
                idx_next     = rd_more ? idx_reg + CNT_ONE : idx_reg;
                if (chk_vld_reg) begin
                    if (op_reg == OP_ALLOC) begin
                        if (NEED_W'(mem_rdata.length) >= need_reg) begin
                            data_next   = OFS_W'(mem_rdata.start + HDR);
                            word_next   = OFS_W'(need_reg - NEED_W'(HDR));
                            in_use_next = alloc_total;
                            peak_next   = (alloc_total > peak_reg) ? alloc_total : peak_reg;
                            if (NEED_W'(mem_rdata.length) == need_reg) begin
                                // extent used up: close the gap
                                idx_next     = chk_reg + CNT_ONE;
                                chk_vld_next = 1'b0;
                                state_next   = S_SHIFT_DN;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = chk_reg[AW-1:0];
                                mem_wdata  = '{start:  mem_rdata.start + LEN_W'(need_reg),
                                               length: mem_rdata.length - LEN_W'(need_reg)};
                                state_next = S_DONE;
                            end
                        end
                    end else begin
                        if (mem_rdata.start > fs_reg) begin
                            cur_next     = mem_rdata;
                            cur_vld_next = 1'b1;
                            ins_next     = chk_reg;
                            state_next   = S_DECIDE;
                        end else begin
                            prev_next     = mem_rdata;
                            prev_vld_next = 1'b1;
                        end
                    end
                end else if (!rd_more) begin
                    // walked past the last extent
                    if (op_reg == OP_ALLOC) begin
                        status_next = ST_NO_FIT;
                        state_next  = S_DONE;
                    end else begin
                        cur_vld_next = 1'b0;
                        ins_next     = count_reg;
                        state_next   = S_DECIDE;
                    end
                end
            end

            // free: reject, merge, extend or insert
            S_DECIDE: begin
                if (bad_span) begin
                    status_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end else if (!left && !right && (count_reg >= CNT_MAX)) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    in_use_next = (in_use_reg >= flen_reg) ? in_use_reg - flen_reg : '0;
                    if (left && right) begin
                        mem_we       = 1'b1;
                        mem_waddr    = ins_m1[AW-1:0];
                        mem_wdata    = '{start:  prev_reg.start,
                                         length: prev_reg.length + flen_reg + cur_reg.length};
                        idx_next     = ins_reg + CNT_ONE;
                        chk_vld_next = 1'b0;
                        state_next   = S_SHIFT_DN;
                    end else if (left) begin
                        mem_we     = 1'b1;
                        mem_waddr  = ins_m1[AW-1:0];
                        mem_wdata  = '{start: prev_reg.start,
                                       length: prev_reg.length + flen_reg};
                        state_next = S_DONE;
                    end else if (right) begin
                        mem_we     = 1'b1;
                        mem_waddr  = ins_reg[AW-1:0];
                        mem_wdata  = '{start: fs_reg, length: cur_reg.length + flen_reg};
                        state_next = S_DONE;
                    end else begin
                        mv_next      = count_reg - ins_reg;
                        idx_next     = count_reg - CNT_ONE;
                        chk_vld_next = 1'b0;
                        state_next   = S_SHIFT_UP;
                    end
                end
            end

            // remove: move entries down by one, read idx, write idx - 1
            S_SHIFT_DN: begin
                chk_vld_next = rd_more;
                chk_next     = idx_reg - CNT_ONE;
                idx_next     = rd_more ? idx_reg + CNT_ONE : idx_reg;
                if (chk_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                end else if (!rd_more) begin
                    count_next = count_reg - CNT_ONE;
                    state_next = S_DONE;
                end
            end

            // insert: move entries up by one from the top, then place the span
            S_SHIFT_UP: begin
                chk_vld_next = (mv_reg != '0);
                chk_next     = idx_reg + CNT_ONE;
                if (mv_reg != '0) begin
                    idx_next = idx_reg - CNT_ONE;
                    mv_next  = mv_reg - CNT_ONE;
                end
                if (chk_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                end else if (mv_reg == '0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = ins_reg[AW-1:0];
                    mem_wdata  = '{start: fs_reg, length: flen_reg};
                    count_next = count_reg + CNT_ONE;
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status:       status_reg,
                                     data_offset:  data_reg,
                                     header_word:  word_reg,
                                     bytes_in_use: in_use_reg,
                                     peak_bytes:   peak_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            pool_size_reg <= POOL_RESET;
            count_reg     <= CNT_ONE;
            in_use_reg    <= '0;
            peak_reg      <= '0;
            chk_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            in_use_reg  <= in_use_next;
            peak_reg    <= peak_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                pool_size_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        need_reg     <= need_next;
        word_reg     <= word_next;
        data_reg     <= data_next;
        status_reg   <= status_next;
        fs_reg       <= fs_next;
        flen_reg     <= flen_next;
        fe_reg       <= fe_next;
        idx_reg      <= idx_next;
        chk_reg      <= chk_next;
        mv_reg       <= mv_next;
        ins_reg      <= ins_next;
        prev_reg     <= prev_next;
        prev_vld_reg <= prev_vld_next;
        cur_reg      <= cur_next;
        cur_vld_reg  <= cur_vld_next;
        m_data_reg   <= m_data_next;
    end

endmodule
